// ===== rtl/core/sptt_pkg.sv =====
// shared types and constants for the sorted priority task table
// no dependencies; imported by every module of the block
package sptt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECNT_W   = 5;

  localparam int unsigned IN_BITS  = MODE_W + ID_W + PRI_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = STATUS_W + PRI_W + ECNT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/sorted_priority_task_table.sv =====
// Sorted priority task table: up to 16 tasks held in ascending priority order in a row of
// slot registers. Each request beat inserts (mode 0), deletes the first matching id (mode 1)
// or searches for an id (mode 2), and returns one result beat with status, the priority
// found on a search and the entry count after the request. A request passes the controller
// steps accept, compare across all slots, and shift and update, which registers the result;
// a new request is taken while the previous result still waits, and the update step waits
// only while an untaken result occupies the output register.
// depends on sptt_pkg, sptt_ctrl and sptt_datapath
module sorted_priority_task_table
  import sptt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // mode[1:0], task_id[17:2], priority_req[25:18]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // status[1:0], found_priority[9:2], entry_count[14:10]
);

  cmd_t  cmd;
  stat_t stat;

  sptt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sptt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/sptt_ctrl.sv =====
// request sequencer for the sorted priority task table
// depends on sptt_pkg; drives sptt_datapath through cmd_t and reads stat_t
module sptt_ctrl
  import sptt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = S_APPLY;
      end
      S_APPLY: begin
        if (stat_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sptt_datapath.sv =====
// slot array, compare row and result register of the sorted priority task table
// depends on sptt_pkg; sequenced by sptt_ctrl
module sptt_datapath
  import sptt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [MODE_W-1:0]   req_mode_q;
  logic [ID_W-1:0]     req_id_q;
  logic [PRI_W-1:0]    req_pri_q;

  logic [ID_W-1:0]     ids_q  [CAPACITY];
  logic [PRI_W-1:0]    pris_q [CAPACITY];
  logic [CNT_W-1:0]    count_q, count_d;

  logic [CAPACITY-1:0] slot_valid;
  logic [CAPACITY-1:0] id_match;
  logic [CAPACITY-1:0] ins_sel;
  logic [CAPACITY-1:0] del_hot;
  logic [CAPACITY-1:0] ins_therm_q;
  logic [CAPACITY-1:0] del_hot_q;
  logic [CAPACITY-1:0] ins_at;
  logic [CAPACITY-1:0] del_therm;

  logic                full;
  logic                hit;
  logic                do_ins;
  logic                do_del;
  logic [PRI_W-1:0]    hit_pri;
  logic [PRI_W-1:0]    fpri_d;
  status_e             status_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PRI_W-1:0]    out_fpri_q;
  logic [ECNT_W-1:0]   out_count_q;
  logic [31:0]         count_wide;

  // compare row
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_valid[i] = count_q > CNT_W'(i);
      id_match[i]   = slot_valid[i] && (ids_q[i] == req_id_q);
      ins_sel[i]    = !slot_valid[i] || (pris_q[i] >= req_pri_q);
    end
    del_hot = id_match & (~id_match + CAPACITY'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_mode_q <= s_axis_tdata[MODE_W-1:0];
      req_id_q   <= s_axis_tdata[MODE_W +: ID_W];
      req_pri_q  <= s_axis_tdata[MODE_W+ID_W +: PRI_W];
    end
    if (cmd_i.scan) begin
      ins_therm_q <= ins_sel;
      del_hot_q   <= del_hot;
    end
  end

  // update decode
  always_comb begin
    full      = count_q >= CNT_W'(CAPACITY);
    hit       = |del_hot_q;
    del_therm = ~(del_hot_q - CAPACITY'(1));
    ins_at[0] = ins_therm_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      ins_at[i] = ins_therm_q[i] & ~ins_therm_q[i-1];
    end
    hit_pri = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pri = hit_pri | (pris_q[i] & {PRI_W{del_hot_q[i]}});
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    fpri_d   = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (req_mode_q)
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = cmd_i.apply;
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          do_del  = cmd_i.apply;
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_MISSING;
        end
      end
      MODE_SEARCH: begin
        if (hit) begin
          fpri_d = hit_pri;
        end else begin
          status_d = ST_MISSING;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // slot row: each slot takes its neighbour on a shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic [ID_W-1:0]  prev_id, next_id;
    logic [PRI_W-1:0] prev_pri, next_pri;

    if (g == 0) begin : g_head
      assign prev_id  = req_id_q;
      assign prev_pri = req_pri_q;
    end else begin : g_body
      assign prev_id  = ids_q[g-1];
      assign prev_pri = pris_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_id  = ids_q[g];
      assign next_pri = pris_q[g];
    end else begin : g_inner
      assign next_id  = ids_q[g+1];
      assign next_pri = pris_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins && ins_at[g]) begin
        ids_q[g]  <= req_id_q;
        pris_q[g] <= req_pri_q;
      end else if (do_ins && ins_therm_q[g]) begin
        ids_q[g]  <= prev_id;
        pris_q[g] <= prev_pri;
      end else if (do_del && del_therm[g]) begin
        ids_q[g]  <= next_id;
        pris_q[g] <= next_pri;
      end
    end
  end

  assign count_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_status_q <= status_d;
      out_fpri_q   <= fpri_d;
      out_count_q  <= count_wide[ECNT_W-1:0];
    end
  end

  assign stat_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {{(OUT_W - OUT_BITS){1'b0}}, out_count_q, out_fpri_q, out_status_q};

endmodule
